// ===== design/sorted_table_insert_delete_assert.svh =====
// Assertion macros shared by the sorted table design.
`ifndef SORTED_TABLE_INSERT_DELETE_ASSERT_SVH
`define SORTED_TABLE_INSERT_DELETE_ASSERT_SVH

// Checks a condition at every rising clock edge outside reset.
`define STID_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define STID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define STID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stid_pkg.sv =====
package stid_pkg;

  localparam int unsigned KEY_W       = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned AREA_W      = 32;
  localparam int unsigned ENTRY_W     = KEY_W + KIND_W + TAG_W + AREA_W;
  localparam int unsigned IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = STATUS_W + 2 * POS_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MVINIT,
    S_MOVE,
    S_COMMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    mv_init;
    logic    mv_step;
    logic    commit;
    logic    resp;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic insert;
    logic hit;
    logic eq;
    logic scan_end;
    logic full;
    logic mv_done;
    logic out_free;
  } stat_t;

endpackage

// ===== design/stid_datapath.sv =====
module stid_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stid_pkg::cmd_t                   cmd_i,
  output stid_pkg::stat_t                  stat_o,
  input  logic [stid_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                             in_tuser_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [stid_pkg::OUT_TDATA_W-1:0] out_tdata_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam int unsigned EW  = stid_pkg::ENTRY_W;
  localparam int unsigned KW  = stid_pkg::KEY_W;
  localparam int unsigned PW  = stid_pkg::POS_W;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  stid_pkg::action_e act_q;
  logic [EW-1:0]     entry_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     ptr_q;
  logic              pend_q;
  logic [CW-1:0]     pos_q;
  logic [CW-1:0]     src_q;
  logic [CW-1:0]     rem_q;
  logic              wpend_q;
  logic [AW-1:0]     wr_addr_q;

  logic                    out_valid_q;
  stid_pkg::status_e       out_status_q;
  logic [PW-1:0]           out_pos_q;
  logic [PW-1:0]           out_cnt_q;

  logic [KW-1:0] rd_key;
  logic [KW-1:0] new_key;
  logic          up;
  logic          match;
  logic          hit;
  logic          scan_end;
  logic [CW-1:0] src_inc;
  logic [CW-1:0] src_dec;
  logic [CW-1:0] pos_sel;
  logic [CW+PW-1:0] pos_ext;
  logic [CW+PW-1:0] cnt_ext;
  logic          out_free;

  assign rd_key  = rd_data_q[KW-1:0];
  assign new_key = entry_q[KW-1:0];
  assign up      = (act_q == stid_pkg::ACT_INSERT);
  assign src_inc = src_q + 1'b1;
  assign src_dec = src_q - 1'b1;

  // Insert stops at the first key that is not smaller, delete at an equal key.
  assign match    = (act_q == stid_pkg::ACT_DELETE) ? (rd_key == new_key) : (rd_key >= new_key);
  assign hit      = pend_q && match;
  assign scan_end = !hit && (ptr_q == n_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.insert   = up;
  assign stat_o.hit      = hit;
  assign stat_o.eq       = (rd_key == new_key);
  assign stat_o.scan_end = scan_end;
  assign stat_o.full     = (n_q == CAP_CNT);
  assign stat_o.mv_done  = (rem_q == '0) && !wpend_q;
  assign stat_o.out_free = out_free;

  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wa      = wr_addr_q;
    wd      = rd_data_q;
    if (cmd_i.scan && !hit && !scan_end) begin
      rd_addr = ptr_q[AW-1:0];
    end
    if (cmd_i.mv_step) begin
      if (rem_q != '0) begin
        rd_addr = src_q[AW-1:0];
      end
      we = wpend_q;
    end
    if (cmd_i.commit && up) begin
      we = 1'b1;
      wa = pos_q[AW-1:0];
      wd = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= stid_pkg::action_e'(in_tuser_i);
      entry_q <= in_tdata_i[EW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      pos_q     <= '0;
      src_q     <= '0;
      rem_q     <= '0;
      wpend_q   <= 1'b0;
      wr_addr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (hit) begin
          pos_q  <= ptr_q - 1'b1;
          pend_q <= 1'b0;
        end else if (scan_end) begin
          pos_q  <= n_q;
          pend_q <= 1'b0;
        end else begin
          ptr_q  <= ptr_q + 1'b1;
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.mv_init) begin
        src_q   <= up ? (n_q - 1'b1) : (pos_q + 1'b1);
        rem_q   <= up ? (n_q - pos_q) : (n_q - pos_q - 1'b1);
        wpend_q <= 1'b0;
      end
      // Each move step reads one slot and writes the entry read in the previous cycle into the slot next to it.
      if (cmd_i.mv_step) begin
        if (rem_q != '0) begin
          wr_addr_q <= up ? src_inc[AW-1:0] : src_dec[AW-1:0];
          src_q     <= up ? src_dec : src_inc;
          rem_q     <= rem_q - 1'b1;
          wpend_q   <= 1'b1;
        end else begin
          wpend_q   <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        n_q <= up ? (n_q + 1'b1) : (n_q - 1'b1);
      end
    end
  end

  assign pos_sel = (cmd_i.code == stid_pkg::STAT_DONE) ? pos_q : '0;
  assign pos_ext = {{PW{1'b0}}, pos_sel};
  assign cnt_ext = {{PW{1'b0}}, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp && out_free) begin
      out_status_q <= cmd_i.code;
      out_pos_q    <= pos_ext[PW-1:0];
      out_cnt_q    <= cnt_ext[PW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {out_cnt_q, out_pos_q, out_status_q};

endmodule

// ===== design/stid_ctrl.sv =====
module stid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  stid_pkg::stat_t stat_i,
  output stid_pkg::cmd_t  cmd_o
);

  stid_pkg::state_e  state_q, state_d;
  stid_pkg::status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stid_pkg::S_IDLE;
      code_q  <= stid_pkg::STAT_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    case (state_q)
      stid_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = stid_pkg::S_SCAN;
          code_d  = stid_pkg::STAT_DONE;
        end
      end
      stid_pkg::S_SCAN: begin
        if (stat_i.insert) begin
          if (stat_i.hit && stat_i.eq) begin
            // A duplicate key wins over a full table.
            code_d  = stid_pkg::STAT_DUP;
            state_d = stid_pkg::S_RESP;
          end else if (stat_i.hit || stat_i.scan_end) begin
            if (stat_i.full) begin
              code_d  = stid_pkg::STAT_FULL;
              state_d = stid_pkg::S_RESP;
            end else begin
              state_d = stid_pkg::S_MVINIT;
            end
          end
        end else begin
          if (stat_i.hit) begin
            state_d = stid_pkg::S_MVINIT;
          end else if (stat_i.scan_end) begin
            code_d  = stid_pkg::STAT_MISSING;
            state_d = stid_pkg::S_RESP;
          end
        end
      end
      stid_pkg::S_MVINIT: begin
        state_d = stid_pkg::S_MOVE;
      end
      stid_pkg::S_MOVE: begin
        if (stat_i.mv_done) begin
          state_d = stid_pkg::S_COMMIT;
        end
      end
      stid_pkg::S_COMMIT: begin
        state_d = stid_pkg::S_RESP;
      end
      stid_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          state_d = stid_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stid_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.code    = code_q;
    case (state_q)
      stid_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      stid_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      stid_pkg::S_MVINIT: begin
        cmd_o.mv_init = 1'b1;
      end
      stid_pkg::S_MOVE: begin
        cmd_o.mv_step = 1'b1;
      end
      stid_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      stid_pkg::S_RESP: begin
        cmd_o.resp = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/sorted_table_insert_delete.sv =====
// Sorted table of up to CAPACITY entries, kept in ascending order of door key.
// The input stream carries one command per transaction: tuser selects insert
// or delete, tdata holds the key and, for an insert, the kind, tag and area.
// The output stream returns one result per command: status, position, count.
// An insert looks for the first key that is not smaller and moves the later
// entries up one slot; a delete looks for an equal key and moves them down.
// A command takes longer the more entries the table holds, and a failed
// command is shorter, as it skips the move: the search and the move both go
// through the single read port of the entry memory, one slot a cycle.
// One command is worked on at a time; the next one is accepted once the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls with a result pending, the next result waits inside
// the block and no further command is accepted until the output frees up.
// Reset empties the table at once; the entry memory itself is not cleared.
module sorted_table_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // door_key [15:0], kind [18:16], tag [34:19], area [66:35], zero fill above
  input  logic [stid_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action [0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status [1:0], position [8:2], count [15:9]
  output logic [stid_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  `include "sorted_table_insert_delete_assert.svh"

  stid_pkg::cmd_t  cmd;
  stid_pkg::stat_t stat;

  stid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata)
  );

  `STID_ASSERT_ALWAYS(a_one_cmd, clk_i, rst_ni,
    $onehot0({cmd.load, cmd.scan, cmd.mv_init, cmd.mv_step, cmd.commit, cmd.resp}),
    "more than one datapath command active")
  `STID_ASSERT_IMPLY(a_fail_pos_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tdata[1:0] != stid_pkg::STAT_DONE),
    m_axis_tdata[8:2] == 7'd0, "failed command reports a nonzero position")
  `STID_ASSERT_NEXT(a_commit_resp, clk_i, rst_ni, cmd.commit, cmd.resp,
    "commit not followed by a result")

endmodule
